FILE: rtl/core/oss_pkg.sv
`default_nettype none

package oss_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_WIDTH    = 3;
  localparam int POS_WIDTH    = 9;
  localparam int DATA_WIDTH   = 32;
  localparam int STATUS_WIDTH = 2;

  // Fan-in of one node of the counting tree.
  localparam int TREE_RADIX = 4;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_INSERT_AT     = 3'd0,
    CMD_INSERT_SORTED = 3'd1,
    CMD_ERASE         = 3'd2,
    CMD_LOWER_BOUND   = 3'd3,
    CMD_UPPER_BOUND   = 3'd4,
    CMD_READ          = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_WIDTH-1:0]         cmd;
    logic [POS_WIDTH-1:0]         position;
    logic signed [DATA_WIDTH-1:0] item_value;
  } req_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] read_value;
    logic [POS_WIDTH-1:0]         found_index;
    logic [POS_WIDTH-1:0]         length;
    status_t                      status;
  } rsp_item_t;

  // Broadcast controls that every cell sees in the same cycle.
  typedef struct packed {
    logic ins;
    logic del;
    logic incl;
  } cell_op_t;

  // Number of radix-4 levels needed to reduce cap leaves to one node.
  function automatic int tree_levels(input int cap);
    int lv;
    lv = ($clog2(cap) + 1) / 2;
    if (lv < 1) begin
      lv = 1;
    end
    return lv;
  endfunction

  // Number of live nodes at a given level of the tree.
  function automatic int tree_nodes(input int cap, input int lvl);
    int n;
    n = cap;
    for (int i = 0; i < lvl; i++) begin
      n = (n + TREE_RADIX - 1) / TREE_RADIX;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/oss_cell.sv
`default_nettype none

module oss_cell #(
  parameter int VALUE_WIDTH = oss_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = 9
) (
  input  wire logic                   clk,
  input  wire oss_pkg::cell_op_t      op,
  input  wire logic [COUNT_WIDTH-1:0] index,
  input  wire logic [COUNT_WIDTH-1:0] pos,
  input  wire logic [COUNT_WIDTH-1:0] count,
  input  wire logic [VALUE_WIDTH-1:0] key,
  input  wire logic [VALUE_WIDTH-1:0] left,
  input  wire logic [VALUE_WIDTH-1:0] right,
  output logic      [VALUE_WIDTH-1:0] value,
  output logic                        hit,
  output logic      [VALUE_WIDTH-1:0] pick
);

  logic at_pos;
  logic from_pos;
  logic less;
  logic equal;

  assign at_pos   = (index == pos);
  assign from_pos = (index >= pos);
  assign less     = ($signed(value) < $signed(key));
  assign equal    = (value == key);

  // An insert opens a gap at pos by taking the left neighbor; an erase closes
  // it by taking the right neighbor.
  always_ff @(posedge clk) begin
    if (op.ins && from_pos) begin
      value <= at_pos ? key : left;
    end else if (op.del && from_pos) begin
      value <= right;
    end
  end

  always_ff @(posedge clk) begin
    hit  <= (index < count) && (less || (op.incl && equal));
    pick <= at_pos ? value : '0;
  end

endmodule

`default_nettype wire

FILE: rtl/core/oss_tree.sv
`default_nettype none

module oss_tree #(
  parameter int CAPACITY    = oss_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = oss_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = 9
) (
  input  wire logic                   clk,
  input  wire logic [CAPACITY-1:0]    hit,
  input  wire logic [VALUE_WIDTH-1:0] pick [CAPACITY],
  output logic      [COUNT_WIDTH-1:0] total,
  output logic      [VALUE_WIDTH-1:0] picked
);

  localparam int LEVELS = oss_pkg::tree_levels(CAPACITY);
  localparam int RADIX  = oss_pkg::TREE_RADIX;

  logic [COUNT_WIDTH-1:0] cnt [LEVELS+1][CAPACITY];
  logic [VALUE_WIDTH-1:0] val [LEVELS+1][CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_leaf
    assign cnt[0][i] = COUNT_WIDTH'(hit[i]);
    assign val[0][i] = pick[i];
  end

  // Every level sums hit counts and ORs the one selected value, then registers.
  for (genvar l = 1; l <= LEVELS; l++) begin : g_level
    localparam int NPREV = oss_pkg::tree_nodes(CAPACITY, l - 1);
    for (genvar j = 0; j < oss_pkg::tree_nodes(CAPACITY, l); j++) begin : g_node
      always_ff @(posedge clk) begin
        logic [COUNT_WIDTH-1:0] s;
        logic [VALUE_WIDTH-1:0] v;
        s = '0;
        v = '0;
        for (int c = 0; c < RADIX; c++) begin
          if (RADIX * j + c < NPREV) begin
            s = s + cnt[l-1][RADIX*j+c];
            v = v | val[l-1][RADIX*j+c];
          end
        end
        cnt[l][j] <= s;
        val[l][j] <= v;
      end
    end
  end

  assign total  = cnt[LEVELS][0];
  assign picked = val[LEVELS][0];

endmodule

`default_nettype wire

FILE: rtl/core/ordered_sequence_store_top.sv
// Ordered sequence store: a row of value cells plus a registered radix-4 count tree.
// Each accepted item is captured, the cells register their hits, each count-tree level
// registers in turn, and the result is committed to the output register. The tree has
// L = ceil(log4(CAPACITY)) levels (L = 4 at 256 entries); a new item is taken only after the previous one commits.
// Reset (rst, synchronous, active high) empties the store and drops any pending result;
// cell contents are not cleared since entries at or past the length are never observed.
`default_nettype none

module ordered_sequence_store_top #(
  parameter int CAPACITY    = oss_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = oss_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire oss_pkg::req_item_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output oss_pkg::rsp_item_t      rsp
);

  // Count width holds 0..CAPACITY; IW is wide enough to compare it with a position.
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int IW     = (CW > oss_pkg::POS_WIDTH) ? CW : oss_pkg::POS_WIDTH;
  localparam int LEVELS = oss_pkg::tree_levels(CAPACITY);
  localparam int TW     = $clog2(LEVELS + 1);

  oss_pkg::state_t state;
  oss_pkg::state_t state_next;

  logic [TW-1:0]                    timer;
  logic [oss_pkg::CMD_WIDTH-1:0]    cmd_q;
  logic [oss_pkg::POS_WIDTH-1:0]    pos_q;
  logic [VALUE_WIDTH-1:0]           key;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;

  logic                             accept;
  logic                             commit;
  logic                             pos_in;
  logic                             full;
  logic [CW-1:0]                    clamp;
  logic [CW-1:0]                    cell_pos;
  oss_pkg::cell_op_t                op;
  oss_pkg::rsp_item_t               result;

  logic [VALUE_WIDTH-1:0]           cell_val [CAPACITY];
  logic [VALUE_WIDTH-1:0]           pick     [CAPACITY];
  logic [CAPACITY-1:0]              hit;
  logic [CW-1:0]                    total;
  logic [VALUE_WIDTH-1:0]           picked;

  assign accept = req_valid && req_ready;

  // The request is captured on acceptance and held while the tree settles.
  // The key is the low VALUE_WIDTH bits of the item value, sign-extended.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.cmd;
      pos_q <= req.position;
      key   <= VALUE_WIDTH'($signed(req.item_value));
    end
  end

  // Position checks against the current length.
  assign pos_in = (IW'(pos_q) < IW'(count));
  assign full   = (count == CW'(CAPACITY));
  assign clamp  = pos_in ? CW'(pos_q) : count;

  // A sorted insert lands at the strict lower-bound count from the tree.
  // Every other command uses the captured position, clamped to the length,
  // which also selects the cell that a read returns.
  assign cell_pos = (cmd_q == oss_pkg::CMD_INSERT_SORTED) ? total : clamp;

  // The row of cells. Each cell compares itself against the key every cycle and
  // shifts to or from its neighbors when the command commits.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end

    oss_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (CW)
    ) u_cell (
      .clk   (clk),
      .op    (op),
      .index (CW'(i)),
      .pos   (cell_pos),
      .count (count),
      .key   (key),
      .left  (left),
      .right (right),
      .value (cell_val[i]),
      .hit   (hit[i]),
      .pick  (pick[i])
    );
  end

  // The tree turns the per-cell hits into a count and returns the selected value.
  oss_tree #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (CW)
  ) u_tree (
    .clk    (clk),
    .hit    (hit),
    .pick   (pick),
    .total  (total),
    .picked (picked)
  );

  // Sequencer: IDLE takes an item, SUM waits for the leaves and every tree
  // level to register, DONE commits once the result register is free.
  always_comb begin
    state_next = state;
    case (state)
      oss_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = oss_pkg::ST_SUM;
        end
      end
      oss_pkg::ST_SUM: begin
        if (timer == '0) begin
          state_next = oss_pkg::ST_DONE;
        end
      end
      oss_pkg::ST_DONE: begin
        if (commit) begin
          state_next = oss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = oss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = (state == oss_pkg::ST_IDLE);
    commit    = (state == oss_pkg::ST_DONE) && (!rsp_valid || rsp_ready);
    op.incl   = (cmd_q == oss_pkg::CMD_UPPER_BOUND);
    op.ins    = commit && !full &&
                ((cmd_q == oss_pkg::CMD_INSERT_AT) || (cmd_q == oss_pkg::CMD_INSERT_SORTED));
    op.del    = commit && pos_in && (cmd_q == oss_pkg::CMD_ERASE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oss_pkg::ST_IDLE;
      timer <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        timer <= TW'(LEVELS);
      end else if ((state == oss_pkg::ST_SUM) && (timer != '0)) begin
        timer <= timer - 1'b1;
      end
    end
  end

  // Result of the command, formed in the commit cycle.
  always_comb begin
    count_next         = count;
    result.read_value  = '0;
    result.found_index = '0;
    result.status      = oss_pkg::STATUS_OK;
    case (cmd_q)
      oss_pkg::CMD_INSERT_AT: begin
        if (full) begin
          result.status = oss_pkg::STATUS_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      oss_pkg::CMD_INSERT_SORTED: begin
        if (full) begin
          result.status = oss_pkg::STATUS_FULL;
        end else begin
          count_next         = count + 1'b1;
          result.found_index = oss_pkg::POS_WIDTH'(total);
        end
      end
      oss_pkg::CMD_ERASE: begin
        if (pos_in) begin
          count_next = count - 1'b1;
        end else begin
          result.status = oss_pkg::STATUS_RANGE;
        end
      end
      oss_pkg::CMD_LOWER_BOUND, oss_pkg::CMD_UPPER_BOUND: begin
        result.found_index = oss_pkg::POS_WIDTH'(total);
      end
      oss_pkg::CMD_READ: begin
        if (pos_in) begin
          result.read_value = oss_pkg::DATA_WIDTH'($signed(picked));
        end else begin
          result.status = oss_pkg::STATUS_RANGE;
        end
      end
      default: begin
        // Unused command codes change nothing and report success.
      end
    endcase
    result.length = oss_pkg::POS_WIDTH'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // Output register: the next item can be taken while this result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

FILE: tb/oss_sequence_checker.sv
`timescale 1ns / 1ps

module oss_sequence_checker #(
  parameter int CAPACITY = oss_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  oss_pkg::req_item_t req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  oss_pkg::rsp_item_t rsp,
  output int                 fail_count,
  output int                 outstanding,
  output int                 checked
);

  localparam int DW = oss_pkg::DATA_WIDTH;
  localparam int PW = oss_pkg::POS_WIDTH;

  // Sequence contents as the block should hold them, front of the queue is index 0.
  logic signed [DW-1:0] seq_values[$];
  oss_pkg::rsp_item_t   awaited_rsp[$];
  oss_pkg::rsp_item_t   want;

  function automatic int count_under(input logic signed [DW-1:0] v,
                                     input bit inclusive);
    int n;
    n = 0;
    foreach (seq_values[i]) begin
      if (seq_values[i] < v || (inclusive && seq_values[i] == v)) begin
        n++;
      end
    end
    return n;
  endfunction

  // Applies one command to the sequence and returns the result it must produce.
  function automatic oss_pkg::rsp_item_t apply_command(input oss_pkg::req_item_t c);
    oss_pkg::rsp_item_t   r;
    int                   pos;
    int                   len;
    int                   slot;
    logic signed [DW-1:0] v;
    r        = '0;
    r.status = oss_pkg::STATUS_OK;
    pos      = int'(c.position);
    len      = seq_values.size();
    v        = c.item_value;
    case (c.cmd)
      oss_pkg::CMD_INSERT_AT: begin
        if (len >= CAPACITY) begin
          r.status = oss_pkg::STATUS_FULL;
        end else begin
          if (pos > len) begin
            pos = len;
          end
          seq_values.insert(pos, v);
        end
      end
      oss_pkg::CMD_INSERT_SORTED: begin
        if (len >= CAPACITY) begin
          r.status = oss_pkg::STATUS_FULL;
        end else begin
          slot          = count_under(v, 1'b0);
          r.found_index = PW'(slot);
          seq_values.insert(slot, v);
        end
      end
      oss_pkg::CMD_ERASE: begin
        if (pos >= len) begin
          r.status = oss_pkg::STATUS_RANGE;
        end else begin
          seq_values.delete(pos);
        end
      end
      oss_pkg::CMD_LOWER_BOUND: r.found_index = PW'(count_under(v, 1'b0));
      oss_pkg::CMD_UPPER_BOUND: r.found_index = PW'(count_under(v, 1'b1));
      oss_pkg::CMD_READ: begin
        if (pos >= len) begin
          r.status = oss_pkg::STATUS_RANGE;
        end else begin
          r.read_value = seq_values[pos];
        end
      end
      default: ;
    endcase
    r.length = PW'(seq_values.size());
    return r;
  endfunction

  task automatic check_field(input string name, input logic [DW-1:0] exp_val,
                             input logic [DW-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 0x%h, got 0x%h", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  // A result accepted in the same cycle as an item always belongs to an older item,
  // so results are matched before the new item is predicted.
  always @(posedge clk) begin
    if (rst) begin
      seq_values.delete();
      awaited_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("result with nothing awaited: 0x%h", rsp);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("found_index", DW'(want.found_index), DW'(rsp.found_index));
          check_field("length", DW'(want.length), DW'(rsp.length));
          check_field("status", DW'(want.status), DW'(rsp.status));
          checked++;
        end
      end
      if (req_valid && req_ready) begin
        awaited_rsp.push_back(apply_command(req));
      end
    end
    outstanding = awaited_rsp.size();
  end

endmodule

FILE: tb/tb_ordered_sequence_store_top.sv
`timescale 1ns / 1ps

module tb_ordered_sequence_store_top;

  localparam int DW           = oss_pkg::DATA_WIDTH;
  localparam int PW           = oss_pkg::POS_WIDTH;
  localparam int CMW          = oss_pkg::CMD_WIDTH;
  localparam int CAP          = oss_pkg::CAPACITY_DEF;
  localparam int POS_ALL      = (1 << PW) - 1;
  localparam int TOTAL_ITEMS  = 1950;
  localparam int IDLE_PCT     = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 20;

  // Command codes the block does not define; they must leave the store untouched.
  localparam logic [CMW-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMW-1:0] CMD_SPARE_B = 3'd7;

  localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] VAL_NEG = -32'sd1;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid;
  logic               req_ready;
  oss_pkg::req_item_t req;
  logic               rsp_valid;
  logic               rsp_ready;
  oss_pkg::rsp_item_t rsp;

  int fail_count;
  int outstanding;
  int checked;

  // Shared between the sender and the receiver: random idling on or off, and a request
  // from the sender for one long receiver hold-off.
  bit gaps_on = 1'b1;
  bit hold_rsp = 1'b0;

  // The sender keeps a rough idea of the length only to steer its stimulus toward
  // a full store and back toward an empty one; the checker does the real prediction.
  int shadow_len = 0;
  int peak_len = 0;
  int full_rejects = 0;
  int n_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ordered_sequence_store_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  oss_sequence_checker #(
    .CAPACITY (CAP)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Half the values come from a narrow window around zero so that equal values and
  // bound ties are common; the rest are fully random, a signed extreme, minus one or zero.
  function automatic logic signed [DW-1:0] pick_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      return $urandom_range(0, 40) - 20;
    end else if (k < 8) begin
      return $urandom();
    end
    case ($urandom_range(0, 3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return VAL_NEG;
      default: return '0;
    endcase
  endfunction

  // Most positions land inside the span that makes sense for the command; the rest
  // cover the whole position field, which also exercises the out-of-range paths.
  function automatic logic [PW-1:0] pick_pos(input int span);
    if (span > 0 && $urandom_range(0, 99) < 85) begin
      return PW'($urandom_range(0, span - 1));
    end
    return PW'($urandom_range(0, POS_ALL));
  endfunction

  // Offers one item and returns at the rising edge where it is accepted. Inputs only
  // change at the falling edge, and an idle gap lowers valid in a step of its own.
  task automatic send_item(input logic [CMW-1:0] op, input logic [PW-1:0] pos,
                           input logic signed [DW-1:0] val);
    if (op == oss_pkg::CMD_INSERT_AT || op == oss_pkg::CMD_INSERT_SORTED) begin
      if (shadow_len < CAP) begin
        shadow_len++;
      end else begin
        full_rejects++;
      end
    end else if (op == oss_pkg::CMD_ERASE && pos < shadow_len) begin
      shadow_len--;
    end
    if (shadow_len > peak_len) begin
      peak_len = shadow_len;
    end
    n_sent++;
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{cmd: op, position: pos, item_value: val};
    @(posedge clk);
    while (!req_ready) begin
      @(posedge clk);
    end
  endtask

  // One random command with the given insert and erase weights in percent; the rest
  // is split between the two bound searches, reads and the undefined codes.
  task automatic issue_random(input int ins_pct, input int del_pct);
    int             r;
    logic [CMW-1:0] op;
    logic [PW-1:0]  pos;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      op  = $urandom_range(0, 1) ? oss_pkg::CMD_INSERT_SORTED : oss_pkg::CMD_INSERT_AT;
      pos = pick_pos(shadow_len + 1);
    end else if (r < ins_pct + del_pct) begin
      op  = oss_pkg::CMD_ERASE;
      pos = pick_pos(shadow_len);
    end else begin
      case ($urandom_range(0, 6))
        0, 1: op = oss_pkg::CMD_LOWER_BOUND;
        2, 3: op = oss_pkg::CMD_UPPER_BOUND;
        4, 5: op = oss_pkg::CMD_READ;
        default: op = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      endcase
      pos = pick_pos(shadow_len);
    end
    send_item(op, pos, pick_value());
  endtask

  // Stops offering items until every result has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request. During the
  // hold-off the sender keeps offering, so the block has to stall its input.
  initial begin
    rsp_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    bit stall_done;
    stall_done = 1'b0;
    req_valid  = 1'b0;
    req        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. On an empty store, reads and erases are out of range and both
    // bound searches return zero whatever the value.
    send_item(oss_pkg::CMD_READ, 0, '0);
    send_item(oss_pkg::CMD_ERASE, 0, '0);
    send_item(oss_pkg::CMD_LOWER_BOUND, 0, VAL_MIN);
    send_item(oss_pkg::CMD_UPPER_BOUND, 0, VAL_MAX);
    // Inserts at a position past the end must append; one at position zero goes to the front.
    send_item(oss_pkg::CMD_INSERT_AT, PW'(POS_ALL), VAL_MAX);
    send_item(oss_pkg::CMD_INSERT_AT, 0, VAL_MIN);
    send_item(oss_pkg::CMD_INSERT_AT, PW'(CAP), 32'sd5);
    // Sorted inserts, including a duplicate and both signed extremes.
    send_item(oss_pkg::CMD_INSERT_SORTED, 0, '0);
    send_item(oss_pkg::CMD_INSERT_SORTED, PW'(POS_ALL), '0);
    send_item(oss_pkg::CMD_INSERT_SORTED, 0, VAL_MAX);
    send_item(oss_pkg::CMD_INSERT_SORTED, 0, VAL_MIN);
    // Bound searches on ties and at the signed extremes.
    send_item(oss_pkg::CMD_LOWER_BOUND, 0, '0);
    send_item(oss_pkg::CMD_UPPER_BOUND, 0, '0);
    send_item(oss_pkg::CMD_LOWER_BOUND, 0, VAL_MIN);
    send_item(oss_pkg::CMD_UPPER_BOUND, 0, VAL_MAX);
    send_item(oss_pkg::CMD_UPPER_BOUND, 0, VAL_NEG);
    // Reads at both ends and beyond the end.
    send_item(oss_pkg::CMD_READ, 0, '0);
    send_item(oss_pkg::CMD_READ, PW'(shadow_len - 1), '0);
    send_item(oss_pkg::CMD_READ, PW'(CAP), '0);
    send_item(oss_pkg::CMD_READ, PW'(POS_ALL), VAL_NEG);
    // Erase just past the end, then the first and the last element.
    send_item(oss_pkg::CMD_ERASE, PW'(shadow_len), '0);
    send_item(oss_pkg::CMD_ERASE, 0, '0);
    send_item(oss_pkg::CMD_ERASE, PW'(shadow_len - 1), '0);
    // Undefined command codes.
    send_item(CMD_SPARE_A, PW'(POS_ALL), VAL_MIN);
    send_item(CMD_SPARE_B, 0, VAL_NEG);
    pause_until_drained();

    // Balanced traffic that slowly grows the store.
    repeat (450) issue_random(45, 25);

    // Fill the store up to capacity. Halfway there, the receiver holds off for a long
    // stretch while items keep coming.
    while (shadow_len < CAP) begin
      if (!stall_done && shadow_len >= CAP / 2) begin
        hold_rsp   = 1'b1;
        stall_done = 1'b1;
      end
      issue_random(80, 5);
    end

    // A full store must refuse both kinds of insert, report its last element and reject accesses past its end.
    repeat (3) send_item(oss_pkg::CMD_INSERT_AT, pick_pos(CAP + 1), pick_value());
    repeat (3) send_item(oss_pkg::CMD_INSERT_SORTED, pick_pos(CAP + 1), pick_value());
    send_item(oss_pkg::CMD_READ, PW'(CAP - 1), '0);
    send_item(oss_pkg::CMD_READ, PW'(CAP), '0);
    send_item(oss_pkg::CMD_ERASE, PW'(CAP), '0);
    send_item(oss_pkg::CMD_UPPER_BOUND, 0, VAL_MAX);
    pause_until_drained();

    // Drain most of the store again.
    while (shadow_len > 16) begin
      issue_random(10, 70);
    end

    // A stretch with no idling on either side.
    gaps_on = 1'b0;
    repeat (300) issue_random(40, 30);
    gaps_on = 1'b1;

    while (n_sent < TOTAL_ITEMS) begin
      issue_random(40, 30);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && outstanding != 0; i++) begin
      @(posedge clk);
    end
    // Run on to catch any result the block should not have produced.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d commands, checked %0d results; peak length %0d, %0d inserts refused",
             n_sent, checked, peak_len, full_rejects);
    $display("as full, one %0d-cycle receiver hold-off, one no-idle stretch.", HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ordered_sequence_store_top] OK");
    end else begin
      $display("[ordered_sequence_store_top] ERROR");
    end
    $finish;
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #(4_000_000);
    $display("Timeout with %0d results still awaited.", outstanding);
    $display("[ordered_sequence_store_top] ERROR");
    $finish;
  end

endmodule
